FILE: rtl/sds_pkg.sv
// shared types and constants for the stick diffusion signal pipeline
// no dependencies
`timescale 1ns / 1ps

package sds_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 14;
    localparam int BVAL_W = 14;
    localparam int DIFF_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_B_VALUE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSIVITY = 1'd1;

    localparam logic [BVAL_W-1:0] BVAL_RESET = 14'd1000;
    localparam logic [DIFF_W-1:0] DIFF_RESET = 12'd1000;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [31:0] EXP_NEG1_Q32 = 32'd1580030169;
    localparam logic [31:0] ROUND_Q32 = 32'h8000_0000;
    localparam logic [31:0] SMALL_GSQ_MAX = 32'd107374;
    // 10^6 = 2^6 * 15625, floor(2^48 / 15625) for the reciprocal multiply
    localparam logic [13:0] DIV_LOW = 14'd15625;
    localparam logic [34:0] RECIP_LOW = 35'd18014398509;
    localparam logic [59:0] EXP_LIMIT_PROD = 60'd12884901888000000;
    localparam logic [15:0] SIG_MAX = 16'hFFFF;
    localparam int TAYLOR_TERMS = 12;
    localparam int POW_STAGES = 11;

    // floor(2^31 / k) for the horner divisions
    localparam logic [31:0] RECIP [1:12] = '{
        32'd2147483648, 32'd1073741824, 32'd715827882, 32'd536870912,
        32'd429496729, 32'd357913941, 32'd306783378, 32'd268435456,
        32'd238609294, 32'd214748364, 32'd195225786, 32'd178956970
    };

    typedef struct packed {
        logic [3:0]  whole;
        logic [29:0] frac;
        logic        force_max;
        logic        force_zero;
    } t_exp_side;

endpackage

FILE: rtl/stick_diffusion_signal.sv
// stick model diffusion signal, top level pipeline and output skid buffer
// depends on sds_pkg, sds_div_pipe, sds_exp_pipe
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  input    | i_in_valid / o_in_ready    | i_fiber_x/y/z, i_grad_x/y/z
//  output   | o_out_valid / i_out_ready  | o_signal
//  config   | i_cfg_we                   | i_cfg_addr, i_cfg_data
//
// one request per cycle unless the output skid buffer is full
// the pipeline runs through the bit-per-stage dot^2 / fsq divider and the 12-term horner chain
// reset is synchronous active low and clears all valid bits and the skid count
// the whole pipeline holds while the 2-entry output skid buffer is full

`timescale 1ns / 1ps

module stick_diffusion_signal #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sds_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [sds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [COMPONENT_BITS-1:0] i_fiber_x,
    input  logic signed [COMPONENT_BITS-1:0] i_fiber_y,
    input  logic signed [COMPONENT_BITS-1:0] i_fiber_z,
    input  logic signed [COMPONENT_BITS-1:0] i_grad_x,
    input  logic signed [COMPONENT_BITS-1:0] i_grad_y,
    input  logic signed [COMPONENT_BITS-1:0] i_grad_z,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [15:0]                    o_signal
);

    logic [sds_pkg::BVAL_W-1:0] r_bval;
    logic [sds_pkg::DIFF_W-1:0] r_diff;
    logic [25:0]                r_bd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bval <= sds_pkg::BVAL_RESET;
            r_diff <= sds_pkg::DIFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sds_pkg::CFG_B_VALUE:     r_bval <= i_cfg_data[sds_pkg::BVAL_W-1:0];
                sds_pkg::CFG_DIFFUSIVITY: r_diff <= i_cfg_data[sds_pkg::DIFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_bd <= 26'(r_bval) * 26'(r_diff);
    end

    logic w_en;
    logic [1:0] r_cnt;
    assign w_en = (r_cnt != 2'd2);
    assign o_in_ready = w_en;

    // align components to q1.15
    logic [COMPONENT_BITS-1:0] w_raw [6];
    logic signed [15:0]        w_al  [6];

    assign w_raw[0] = i_fiber_x;
    assign w_raw[1] = i_fiber_y;
    assign w_raw[2] = i_fiber_z;
    assign w_raw[3] = i_grad_x;
    assign w_raw[4] = i_grad_y;
    assign w_raw[5] = i_grad_z;

    for (genvar c = 0; c < 6; c++) begin : g_align
        if (COMPONENT_BITS >= 16) begin : g_trim
            assign w_al[c] = w_raw[c][COMPONENT_BITS-1 -: 16];
        end else begin : g_pad
            assign w_al[c] = {w_raw[c], {(16 - COMPONENT_BITS){1'b0}}};
        end
    end

    // stage 1: aligned components
    logic               r1_v;
    logic signed [15:0] r1_c [6];

    // stage 2: products
    logic               r2_v;
    logic signed [31:0] r2_gg [3];
    logic signed [31:0] r2_ff [3];
    logic signed [31:0] r2_fg [3];

    // stage 3: sums
    logic               r3_v;
    logic [31:0]        r3_gsq;
    logic [31:0]        r3_fsq;
    logic signed [33:0] r3_dot;

    // stage 4: magnitude and flags
    logic        r4_v;
    logic [31:0] r4_gsq;
    logic [31:0] r4_fsq;
    logic [31:0] r4_ad;
    logic        r4_fmax;

    // stage 5: squared dot
    logic        r5_v;
    logic [63:0] r5_num;
    logic [31:0] r5_fsq;
    logic [31:0] r5_gsq;
    logic        r5_fmax;

    logic signed [33:0] n_dot;
    logic [33:0]        n_adw;

    assign n_dot = 34'(r2_fg[0]) + 34'(r2_fg[1]) + 34'(r2_fg[2]);
    assign n_adw = r3_dot[33] ? 34'(-r3_dot) : 34'(r3_dot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 6; c++) begin
                r1_c[c] <= w_al[c];
            end
            for (int c = 0; c < 3; c++) begin
                r2_gg[c] <= r1_c[c+3] * r1_c[c+3];
                r2_ff[c] <= r1_c[c] * r1_c[c];
                r2_fg[c] <= r1_c[c] * r1_c[c+3];
            end
            r3_gsq  <= $unsigned(r2_gg[0]) + $unsigned(r2_gg[1]) + $unsigned(r2_gg[2]);
            r3_fsq  <= $unsigned(r2_ff[0]) + $unsigned(r2_ff[1]) + $unsigned(r2_ff[2]);
            r3_dot  <= n_dot;
            r4_gsq  <= r3_gsq;
            r4_fsq  <= r3_fsq;
            r4_ad   <= n_adw[31:0];
            r4_fmax <= (r3_gsq <= sds_pkg::SMALL_GSQ_MAX) || (r3_fsq == 32'd0);
            r5_num  <= 64'(r4_ad) * 64'(r4_ad);
            r5_fsq  <= r4_fsq;
            r5_gsq  <= r4_gsq;
            r5_fmax <= r4_fmax;
        end
    end

    // q = dot^2 / fsq
    logic        w_d1_v;
    logic [31:0] w_d1_q;
    logic [32:0] w_d1_side;

    sds_div_pipe #(
        .NUM_W  (64),
        .DIV_W  (32),
        .QUO_W  (32),
        .SIDE_W (33)
    ) u_div_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_v),
        .i_num   (r5_num),
        .i_div   (r5_fsq),
        .i_side  ({r5_gsq, r5_fmax}),
        .o_valid (w_d1_v),
        .o_quo   (w_d1_q),
        .o_side  (w_d1_side)
    );

    // stage 6: p = gsq * q >> 30
    logic        r6_v;
    logic [33:0] r6_p;
    logic        r6_fmax;
    logic [63:0] n_gq;

    // stage 7: b * d * p in two partial products
    logic        r7_v;
    logic [42:0] r7_pph;
    logic [42:0] r7_ppl;
    logic        r7_fmax;

    // stage 8: full exponent product over 2^6 and flush check
    logic        r8_v;
    logic [47:0] r8_num;
    logic        r8_fmax;
    logic        r8_flush;
    logic [59:0] n_prod;

    // stage 9: partial products with the reciprocal of 15625
    logic        r9_v;
    logic [58:0] r9_pph;
    logic [58:0] r9_ppl;
    logic [47:0] r9_num;
    logic        r9_fmax;
    logic        r9_flush;

    // stage 10: quotient estimate, low by at most one
    logic        r10_v;
    logic [33:0] r10_qe;
    logic [47:0] r10_num;
    logic        r10_fmax;
    logic        r10_flush;

    // stage 11: corrected exponent x = product / 10^6
    logic        r11_v;
    logic [33:0] r11_x;
    logic        r11_fmax;
    logic        r11_flush;

    logic [82:0] n_qsum;
    logic [47:0] n_qm;
    logic [47:0] n_rem;

    assign n_gq   = 64'(w_d1_side[32:1]) * 64'(w_d1_q);
    assign n_prod = {r7_pph, 17'd0} + 60'(r7_ppl);
    assign n_qsum = {r9_pph, 24'd0} + 83'(r9_ppl);
    assign n_qm   = 48'(r10_qe) * 48'(sds_pkg::DIV_LOW);
    assign n_rem  = r10_num - n_qm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
        end else if (w_en) begin
            r6_v  <= w_d1_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_p      <= n_gq[63:30];
            r6_fmax   <= w_d1_side[0];
            r7_pph    <= 43'(r_bd) * 43'(r6_p[33:17]);
            r7_ppl    <= 43'(r_bd) * 43'(r6_p[16:0]);
            r7_fmax   <= r6_fmax;
            r8_num    <= n_prod[53:6];
            r8_fmax   <= r7_fmax;
            r8_flush  <= (n_prod >= sds_pkg::EXP_LIMIT_PROD);
            r9_pph    <= 59'(r8_num[47:24]) * 59'(sds_pkg::RECIP_LOW);
            r9_ppl    <= 59'(r8_num[23:0]) * 59'(sds_pkg::RECIP_LOW);
            r9_num    <= r8_num;
            r9_fmax   <= r8_fmax;
            r9_flush  <= r8_flush;
            r10_qe    <= n_qsum[81:48];
            r10_num   <= r9_num;
            r10_fmax  <= r9_fmax;
            r10_flush <= r9_flush;
            r11_x     <= (n_rem >= 48'(sds_pkg::DIV_LOW)) ? r10_qe + 34'd1 : r10_qe;
            r11_fmax  <= r10_fmax;
            r11_flush <= r10_flush;
        end
    end

    sds_pkg::t_exp_side w_exp_side;
    logic               w_exp_v;
    logic [15:0]        w_exp_sig;

    assign w_exp_side.whole      = r11_x[33:30];
    assign w_exp_side.frac       = r11_x[29:0];
    assign w_exp_side.force_max  = r11_fmax;
    assign w_exp_side.force_zero = r11_flush;

    sds_exp_pipe u_exp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r11_v),
        .i_side   (w_exp_side),
        .o_valid  (w_exp_v),
        .o_signal (w_exp_sig)
    );

    // output skid buffer
    logic [15:0] r_q0;
    logic [15:0] r_q1;
    logic        w_push;
    logic        w_pop;

    assign w_push = w_en && w_exp_v;
    assign w_pop  = (r_cnt != 2'd0) && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case (r_cnt)
                2'd0: if (w_push) r_cnt <= 2'd1;
                2'd1: if (w_push && !w_pop) r_cnt <= 2'd2;
                      else if (!w_push && w_pop) r_cnt <= 2'd0;
                2'd2: if (w_pop) r_cnt <= 2'd1;
                default: r_cnt <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cnt)
            2'd0: if (w_push) r_q0 <= w_exp_sig;
            2'd1: if (w_push && w_pop) r_q0 <= w_exp_sig;
                  else if (w_push) r_q1 <= w_exp_sig;
            2'd2: if (w_pop) r_q0 <= r_q1;
            default: ;
        endcase
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_signal    = r_q0;

`ifndef ASSERT_OFF
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_out_ready) |=> (r_cnt == 2'd2))
        else $error("skid buffer lost an entry while stalled");

    a_pop_from_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && i_out_ready) |=> (o_signal == $past(r_q1)))
        else $error("second skid entry not moved to head");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

FILE: rtl/sds_div_pipe.sv
// restoring divider, one quotient bit per pipeline stage
// no dependencies
`timescale 1ns / 1ps

module sds_div_pipe #(
    parameter int NUM_W = 64,
    parameter int DIV_W = 32,
    parameter int QUO_W = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DIV_W-1:0]  i_div,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic [DIV_W-1:0]  w_rem  [QUO_W+1];
    logic [QUO_W-1:0]  w_low  [QUO_W+1];
    logic [QUO_W-1:0]  w_quo  [QUO_W+1];
    logic [DIV_W-1:0]  w_div  [QUO_W+1];
    logic [SIDE_W-1:0] w_side [QUO_W+1];
    logic              w_vld  [QUO_W+1];

    assign w_rem[0]  = DIV_W'(i_num[NUM_W-1:QUO_W]);
    assign w_low[0]  = i_num[QUO_W-1:0];
    assign w_quo[0]  = '0;
    assign w_div[0]  = i_div;
    assign w_side[0] = i_side;
    assign w_vld[0]  = i_valid;

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [DIV_W:0]    n_trial;
        logic [DIV_W:0]    n_diff;
        logic              n_ge;
        logic [DIV_W-1:0]  r_rem;
        logic [QUO_W-1:0]  r_low;
        logic [QUO_W-1:0]  r_quo;
        logic [DIV_W-1:0]  r_div;
        logic [SIDE_W-1:0] r_side;
        logic              r_vld;

        assign n_trial = {w_rem[s], w_low[s][QUO_W-1]};
        assign n_diff  = n_trial - {1'b0, w_div[s]};
        assign n_ge    = (n_trial >= {1'b0, w_div[s]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_ge ? n_diff[DIV_W-1:0] : n_trial[DIV_W-1:0];
                r_low  <= w_low[s] << 1;
                r_quo  <= {w_quo[s][QUO_W-2:0], n_ge};
                r_div  <= w_div[s];
                r_side <= w_side[s];
            end
        end

        assign w_rem[s+1]  = r_rem;
        assign w_low[s+1]  = r_low;
        assign w_quo[s+1]  = r_quo;
        assign w_div[s+1]  = r_div;
        assign w_side[s+1] = r_side;
        assign w_vld[s+1]  = r_vld;
    end

    assign o_valid = w_vld[QUO_W];
    assign o_quo   = w_quo[QUO_W];
    assign o_side  = w_side[QUO_W];

endmodule

FILE: rtl/sds_exp_pipe.sv
// exp(-x) pipeline: horner taylor steps, e^-1 powers, q0.16 rounding
// depends on sds_pkg
`timescale 1ns / 1ps

module sds_exp_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  sds_pkg::t_exp_side i_side,
    output logic              o_valid,
    output logic [15:0]       o_signal
);

    localparam int NT = sds_pkg::TAYLOR_TERMS;
    localparam int NP = sds_pkg::POW_STAGES;

    logic [30:0]        w_hacc [NT+1];
    sds_pkg::t_exp_side w_hs   [NT+1];
    logic               w_hv   [NT+1];

    assign w_hacc[0] = sds_pkg::Q30_ONE;
    assign w_hs[0]   = i_side;
    assign w_hv[0]   = i_valid;

    // three stages per term: product, reciprocal product, correct and subtract
    for (genvar j = 0; j < NT; j++) begin : g_horner
        localparam int K = NT - j;
        logic [60:0]        n_prod;
        logic [61:0]        n_rprod;
        logic [33:0]        n_qk;
        logic [33:0]        n_rem;
        logic [29:0]        n_q;
        logic [29:0]        r_a_m;
        sds_pkg::t_exp_side r_a_s;
        logic               r_a_v;
        logic [29:0]        r_b_m;
        logic [29:0]        r_b_q;
        sds_pkg::t_exp_side r_b_s;
        logic               r_b_v;
        logic [30:0]        r_c_acc;
        sds_pkg::t_exp_side r_c_s;
        logic               r_c_v;

        assign n_prod  = 61'(w_hs[j].frac) * 61'(w_hacc[j]);
        assign n_rprod = 62'(r_a_m) * 62'(sds_pkg::RECIP[K]);
        assign n_qk    = 34'(r_b_q) * 34'(K);
        assign n_rem   = 34'(r_b_m) - n_qk;
        assign n_q     = (n_rem >= 34'(K)) ? r_b_q + 30'd1 : r_b_q;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_v <= 1'b0;
                r_b_v <= 1'b0;
                r_c_v <= 1'b0;
            end else if (i_en) begin
                r_a_v <= w_hv[j];
                r_b_v <= r_a_v;
                r_c_v <= r_b_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_m   <= n_prod[59:30];
                r_a_s   <= w_hs[j];
                r_b_m   <= r_a_m;
                r_b_q   <= n_rprod[60:31];
                r_b_s   <= r_a_s;
                r_c_acc <= sds_pkg::Q30_ONE - 31'(n_q);
                r_c_s   <= r_b_s;
            end
        end

        assign w_hacc[j+1] = r_c_acc;
        assign w_hs[j+1]   = r_c_s;
        assign w_hv[j+1]   = r_c_v;
    end

    logic [30:0]        w_pacc [NP+1];
    sds_pkg::t_exp_side w_ps   [NP+1];
    logic               w_pv   [NP+1];

    assign w_pacc[0] = w_hacc[NT];
    assign w_ps[0]   = w_hs[NT];
    assign w_pv[0]   = w_hv[NT];

    // stage i multiplies by e^-1 when the integer part exceeds i
    for (genvar i = 0; i < NP; i++) begin : g_pow
        logic [62:0]        n_mul;
        logic [30:0]        r_acc;
        sds_pkg::t_exp_side r_s;
        logic               r_v;

        assign n_mul = 63'(w_pacc[i]) * 63'(sds_pkg::EXP_NEG1_Q32)
                     + 63'(sds_pkg::ROUND_Q32);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_pv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc <= (w_ps[i].whole > 4'(i)) ? n_mul[62:32] : w_pacc[i];
                r_s   <= w_ps[i];
            end
        end

        assign w_pacc[i+1] = r_acc;
        assign w_ps[i+1]   = r_s;
        assign w_pv[i+1]   = r_v;
    end

    logic [31:0] n_round;
    logic [17:0] n_sig;
    logic [15:0] n_out;
    logic        r_out_v;
    logic [15:0] r_out;

    assign n_round = 32'(w_pacc[NP]) + 32'd8192;
    assign n_sig   = n_round[31:14];

    always_comb begin
        if (w_ps[NP].force_max) begin
            n_out = sds_pkg::SIG_MAX;
        end else if (w_ps[NP].force_zero) begin
            n_out = '0;
        end else if (n_sig > 18'(sds_pkg::SIG_MAX)) begin
            n_out = sds_pkg::SIG_MAX;
        end else begin
            n_out = n_sig[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= w_pv[NP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_v;
    assign o_signal = r_out;

endmodule

FILE: bench/stick_diffusion_signal_test.sv
// testbench for stick_diffusion_signal: random and directed fiber/gradient requests
// scoreboard class predicts the attenuated signal; depends on sds_pkg and the rtl
`timescale 1ns / 1ps

module stick_diffusion_signal_test;

    class signal_scoreboard;
        logic [13:0] bval;
        logic [11:0] diff;
        logic [15:0] pending[$];
        int errors;

        function new();
            bval = sds_pkg::BVAL_RESET;
            diff = sds_pkg::DIFF_RESET;
            errors = 0;
        endfunction

        function logic [15:0] attenuation(logic signed [15:0] f[3], logic signed [15:0] g[3]);
            longint gsq, fsq, dt, q, p, x, n, r, acc, s, ad;
            gsq = 0; fsq = 0; dt = 0; q = 0;
            for (int i = 0; i < 3; i++) begin
                gsq += longint'(g[i]) * longint'(g[i]);
                fsq += longint'(f[i]) * longint'(f[i]);
                dt += longint'(f[i]) * longint'(g[i]);
            end
            if (gsq * 10000 <= 64'h4000_0000) return 16'hFFFF;
            if (fsq != 0) begin
                ad = (dt < 0) ? -dt : dt;
                q = longint'(($unsigned(ad) * $unsigned(ad)) / $unsigned(fsq));
            end
            p = longint'(($unsigned(gsq) * $unsigned(q)) >> 30);
            x = (longint'(bval) * longint'(diff) * p) / 1000000;
            n = x >>> 30;
            r = x & 64'h3FFF_FFFF;
            if (n >= 12) return 16'h0000;
            acc = 64'h4000_0000;
            for (int k = 12; k >= 1; k--)
                acc = 64'h4000_0000 - ((r * acc) >>> 30) / k;
            for (int i = 0; i < n; i++)
                acc = longint'((64'(acc) * 64'd1580030169 + 64'h8000_0000) >> 32);
            s = (acc * 65536 + 64'h2000_0000) >>> 30;
            if (s > 65535) s = 65535;
            return s[15:0];
        endfunction

        function void note_request(logic signed [15:0] f[3], logic signed [15:0] g[3]);
            pending.push_back(attenuation(f, g));
        endfunction

        function void check_signal(logic [15:0] got);
            logic [15:0] want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected signal %0d", got);
                return;
            end
            want = pending.pop_front();
            if (want !== got) begin
                errors++;
                if (errors <= 10) $display("signal mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_cfg_we, i_in_valid, i_out_ready, o_in_ready, o_out_valid;
    logic [sds_pkg::CFG_IDX_W-1:0] i_cfg_addr;
    logic [sds_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic signed [15:0] i_fiber_x, i_fiber_y, i_fiber_z, i_grad_x, i_grad_y, i_grad_z;
    logic [15:0] o_signal;
    signal_scoreboard sb;
    int cycles;
    bit calm, done;

    stick_diffusion_signal dut (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_addr = sds_pkg::CFG_B_VALUE; i_cfg_data = 0;
        i_in_valid = 0; i_out_ready = 0;
        {i_fiber_x, i_fiber_y, i_fiber_z, i_grad_x, i_grad_y, i_grad_z} = '0;
    end

    initial sb = new();

    // result side with random stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_signal(o_signal);
        end
    end

    initial begin
        int hold;
        @(posedge i_clk);
        forever begin
            i_out_ready <= 1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (!calm && $urandom_range(0, 1)) begin
                hold = $urandom_range(1, 14);
                i_out_ready <= 0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [sds_pkg::CFG_IDX_W-1:0] idx,
                             logic [sds_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we <= 1; i_cfg_addr <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == sds_pkg::CFG_B_VALUE) sb.bval = val;
        else sb.diff = val[11:0];
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (130) @(posedge i_clk);
    endtask

    task automatic send(logic signed [15:0] fx, fy, fz, gx, gy, gz);
        logic signed [15:0] f[3], g[3];
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_fiber_x <= fx; i_fiber_y <= fy; i_fiber_z <= fz;
        i_grad_x <= gx; i_grad_y <= gy; i_grad_z <= gz;
        f = '{fx, fy, fz}; g = '{gx, gy, gz};
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(f, g);
    endtask

    task automatic random_item();
        logic signed [15:0] v[6];
        int mode;
        for (int i = 0; i < 6; i++) v[i] = 16'($urandom);
        mode = $urandom_range(0, 9);
        // mostly gradients of sane norm so the exponent stays in range
        if (mode < 6) for (int i = 3; i < 6; i++) v[i] = $signed(v[i]) >>> $urandom_range(1, 4);
        else if (mode == 6) for (int i = 3; i < 6; i++) v[i] = $signed(v[i]) >>> 9;
        else if (mode == 7) for (int i = 0; i < 3; i++) v[i] = $signed(v[i]) >>> 14;
        send(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    initial begin
        logic [13:0] bvals[5] = '{14'd0, 14'd1000, 14'd10000, 14'h3FFF, 14'd3000};
        logic [11:0] dvals[5] = '{12'd4095, 12'd1000, 12'd0, 12'hFFF, 12'd1700};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, small gradient, zero fiber, large exponent
        send(16'sh7FFF, 0, 0, 16'sh7FFF, 0, 0);
        send(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send(0, 0, 0, 16'sh4000, 16'sh1000, 0);
        send(16'sh1234, 0, 0, 16'sd327, 0, 0);
        send(16'sh1234, 0, 0, 16'sd328, 0, 0);
        send(16'sh1234, 0, 0, 16'sd190, 16'sd190, 16'sd190);
        send(0, 16'sh4000, 0, 16'sh4000, 0, 0);
        send(16'sh0001, 16'sh0001, 16'sh0001, 16'sh5A82, 16'sh5A82, 0);
        send(-16'sd1, 16'sh7FFF, -16'sh8000, -16'sh2000, 16'sh2000, 16'sh6000);
        drain();
        write_reg(sds_pkg::CFG_B_VALUE, 14'h3FFF);
        write_reg(sds_pkg::CFG_DIFFUSIVITY, 14'hFFF);
        send(16'sh7FFF, 0, 0, 16'sh7FFF, 0, 0);
        send(16'sh7FFF, 0, 0, 16'sh0800, 0, 0);
        send(16'sh7FFF, 16'sh7FFF, 0, 16'sh0400, 16'sh0200, 0);
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_reg(sds_pkg::CFG_B_VALUE, bvals[ph]);
            write_reg(sds_pkg::CFG_DIFFUSIVITY, 14'(dvals[ph]));
            if (ph == 4) calm = 1;
            for (int n = 0; n < 300; n++) random_item();
        end
        i_in_valid <= 0;
        drain();
        if (sb.errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule

FILE: stick_diffusion_signal.f
rtl/sds_pkg.sv
rtl/sds_div_pipe.sv
rtl/sds_exp_pipe.sv
rtl/stick_diffusion_signal.sv
bench/stick_diffusion_signal_test.sv
